/* hw/rtl/lzwe_pkg.sv */
// shared types and constants of the lzw variable width encoder
package lzwe_pkg;

	localparam int SYM_W      = 8;
	localparam int CODE_W     = 12;
	localparam int CWIDTH_W   = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CODE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EARLY_CHANGE    = 1'd1;

	localparam logic [CFG_DATA_W-1:0] MAX_LEN_RESET = 4'd12;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
		logic             first;
	} item_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] max_code_length;
		logic                  early_change;
	} cfg_t;

	// handoff between the front queue and the back sequencer
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

/* hw/rtl/lzw_variable_width_encoder_core.sv */
// top level of the lzw variable width encoder
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  in       | in_valid / in_ready    | symbol, stream_end
//  out      | out_valid / out_ready  | code, code_width, final_code
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one word at a time: a hit passes through S_IDLE, S_HEAD, one S_WALK step per child
// node visited and S_FIN; a miss adds S_MISS and S_LINK after any walk; the first word
// of a stream goes S_IDLE, S_CLR0, S_FIN; restart and end of stream add S_RST and S_EOI
// for the extra code; the sibling-chain walk visits one node per cycle through the
// dictionary memories; each code waits in a single output register
// reset clears control state and root valid bits only; dictionary ram holds junk
// the two-entry input queue keeps accepting while the back end stalls on out_ready, until it is full
module lzw_variable_width_encoder_core import lzwe_pkg::*; #(
	parameter int SYMBOL_BITS   = 8,
	parameter int MAX_CODE_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [SYM_W-1:0]      symbol,
	input  logic                  stream_end,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic [CODE_W-1:0]     code,
	output logic [CWIDTH_W-1:0]   code_width,
	output logic                  final_code,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t        cfg_q;
	queue_head_t head;
	logic        pop;

	// config writes always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_code_length <= MAX_LEN_RESET;
			cfg_q.early_change    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_CODE_LENGTH: cfg_q.max_code_length <= cfg_data;
				REG_EARLY_CHANGE:    cfg_q.early_change    <= cfg_data[0];
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	// front: classify words and queue them
	lzwe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.symbol     (symbol),
		.stream_end (stream_end),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.head       (head),
		.pop        (pop)
	);

	// back: dictionary search, insert and code emission
	lzwe_back #(
		.SYMBOL_BITS   (SYMBOL_BITS),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.pop        (pop),
		.code       (code),
		.code_width (code_width),
		.final_code (final_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule

/* hw/rtl/lzwe_front.sv */
// front end: accepts words, marks stream start and end, two-entry queue
module lzwe_front import lzwe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SYM_W-1:0]  symbol,
	input  logic              stream_end,
	input  logic              in_valid,
	output logic              in_ready,
	output queue_head_t       head,
	input  logic              pop
);

	item_t       entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        started_q;
	logic        push;

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign head.valid = (count_q != 2'd0);
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			count_q   <= 2'd0;
			started_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q  <= ~wr_ptr_q;
				started_q <= ~stream_end;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{symbol: symbol, last: stream_end, first: ~started_q};
		end
	end

endmodule

/* hw/rtl/lzwe_back.sv */
// back end: dictionary walk, insert, width tracking and code output register
module lzwe_back import lzwe_pkg::*; #(
	parameter int SYMBOL_BITS   = 8,
	parameter int MAX_CODE_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  queue_head_t         head,
	output logic                pop,
	output logic [CODE_W-1:0]   code,
	output logic [CWIDTH_W-1:0] code_width,
	output logic                final_code,
	output logic                out_valid,
	input  logic                out_ready
);

	localparam int NB    = MAX_CODE_BITS;
	localparam int SB    = SYMBOL_BITS;
	localparam int DEPTH = 2 ** NB;
	localparam int ROOTS = 2 ** SB;
	localparam int WW    = $clog2(NB + 3);
	localparam int MW    = $clog2(NB + 1);

	localparam logic [NB-1:0] CLEAR_CODE = NB'(ROOTS);
	localparam logic [NB-1:0] EOI_CODE   = NB'(ROOTS + 1);
	localparam logic [NB:0]   FIRST_FREE = (NB + 1)'(ROOTS + 2);
	localparam logic [WW-1:0] BASE_W     = WW'(SB + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR0 = 4'd1;
	localparam logic [3:0] S_HEAD = 4'd2;
	localparam logic [3:0] S_WALK = 4'd3;
	localparam logic [3:0] S_MISS = 4'd4;
	localparam logic [3:0] S_LINK = 4'd5;
	localparam logic [3:0] S_RST  = 4'd6;
	localparam logic [3:0] S_FIN  = 4'd7;
	localparam logic [3:0] S_EOI  = 4'd8;

	function automatic logic is_pow2(input logic [NB+1:0] x);
		return (x != '0) && ((x & (x - 1'b1)) == '0);
	endfunction

	function automatic logic [WW-1:0] pow2_bits(input logic [NB+1:0] x);
		logic [WW-1:0] r;
		r = '0;
		for (int i = 0; i < NB + 2; i++) begin
			if (x[i]) r = WW'(i + 1);
		end
		return r;
	endfunction

	// dictionary: first child, next sibling and symbol of each code
	logic [NB-1:0] fc_mem [DEPTH];
	logic [NB-1:0] ns_mem [DEPTH];
	logic [SB-1:0] sy_mem [DEPTH];
	logic [NB-1:0] fc_rd_q;
	logic [NB-1:0] ns_rd_q;
	logic [SB-1:0] sy_rd_q;

	logic [3:0]      state_q;
	logic [SB-1:0]   sym_q;
	logic            last_q;
	logic [NB-1:0]   prefix_q;
	logic [NB:0]     nf_q;
	logic [WW-1:0]   cw_q;
	logic [NB-1:0]   head_q;
	logic [NB-1:0]   node_q;
	logic [ROOTS-1:0] rv_q;

	logic            out_valid_q;
	logic [NB-1:0]   out_code_q;
	logic [WW-1:0]   out_w_q;
	logic            out_fin_q;

	logic            out_free;
	logic            emit;
	logic [NB-1:0]   emit_code;
	logic            emit_fin;
	logic            fc_we;
	logic [NB-1:0]   fc_waddr;
	logic [NB-1:0]   fc_wdata;
	logic            nd_we;
	logic [NB-1:0]   nd_raddr;
	logic            root_c;
	logic [NB-1:0]   head_c;
	logic [NB-1:0]   slot;
	logic [NB+1:0]   nf_ext;
	logic [NB+1:0]   nf_inc;
	logic [NB+1:0]   nf_inc2;
	logic [NB+1:0]   limit_c;
	logic [MW-1:0]   m_sat;
	logic            restart_c;
	logic [NB+11:0]  code_ext;
	logic [WW+3:0]   w_ext;

	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == S_IDLE) && head.valid;
	assign slot     = nf_q[NB-1:0];
	assign root_c   = (prefix_q[NB-1:SB] == '0);
	assign head_c   = (root_c && !rv_q[prefix_q[SB-1:0]]) ? '0 : fc_rd_q;
	assign nf_ext   = {1'b0, nf_q};
	assign nf_inc   = nf_ext + (NB + 2)'(1);
	assign nf_inc2  = nf_ext + (NB + 2)'(2);

	always_comb begin
		if (int'(cfg.max_code_length) < SB + 1) begin
			m_sat = MW'(SB + 1);
		end else if (int'(cfg.max_code_length) > NB) begin
			m_sat = MW'(NB);
		end else begin
			m_sat = MW'(cfg.max_code_length);
		end
		limit_c   = (NB + 2)'(1) << m_sat;
		restart_c = cfg.early_change ? (nf_inc2 >= limit_c) : (nf_inc >= limit_c);
	end

	always_comb begin
		emit      = 1'b0;
		emit_code = prefix_q;
		emit_fin  = 1'b0;
		fc_we     = 1'b0;
		fc_waddr  = slot;
		fc_wdata  = '0;
		nd_we     = 1'b0;
		case (state_q)
			S_HEAD:  nd_raddr = head_c;
			S_WALK:  nd_raddr = ns_rd_q;
			default: nd_raddr = node_q;
		endcase
		case (state_q)
			S_CLR0: begin
				emit      = out_free;
				emit_code = CLEAR_CODE;
			end
			S_MISS: begin
				emit  = out_free;
				nd_we = out_free;
				fc_we = out_free;
			end
			S_LINK: begin
				fc_we    = 1'b1;
				fc_waddr = prefix_q;
				fc_wdata = slot;
			end
			S_RST: begin
				emit      = out_free;
				emit_code = CLEAR_CODE;
			end
			S_FIN: begin
				emit = last_q && out_free;
			end
			S_EOI: begin
				emit      = out_free;
				emit_code = EOI_CODE;
				emit_fin  = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		fc_rd_q <= fc_mem[prefix_q];
		if (fc_we) begin
			fc_mem[fc_waddr] <= fc_wdata;
		end
	end

	always_ff @(posedge clk) begin
		ns_rd_q <= ns_mem[nd_raddr];
		sy_rd_q <= sy_mem[nd_raddr];
		if (nd_we) begin
			ns_mem[slot] <= head_q;
			sy_mem[slot] <= sym_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sym_q    <= '0;
			last_q   <= 1'b0;
			prefix_q <= '0;
			nf_q     <= FIRST_FREE;
			cw_q     <= BASE_W;
			head_q   <= '0;
			node_q   <= '0;
			rv_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						sym_q   <= head.item.symbol[SB-1:0];
						last_q  <= head.item.last;
						state_q <= head.item.first ? S_CLR0 : S_HEAD;
					end
				end
				S_CLR0: begin
					if (out_free) begin
						cw_q     <= BASE_W;
						prefix_q <= NB'(sym_q);
						state_q  <= S_FIN;
					end
				end
				S_HEAD: begin
					head_q  <= head_c;
					node_q  <= head_c;
					state_q <= (head_c == '0) ? S_MISS : S_WALK;
				end
				S_WALK: begin
					if (sy_rd_q == sym_q) begin
						prefix_q <= node_q;
						state_q  <= S_FIN;
					end else if (ns_rd_q == '0) begin
						state_q <= S_MISS;
					end else begin
						node_q <= ns_rd_q;
					end
				end
				S_MISS: begin
					if (out_free) begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					if (root_c) begin
						rv_q[prefix_q[SB-1:0]] <= 1'b1;
					end
					nf_q     <= nf_inc[NB:0];
					prefix_q <= NB'(sym_q);
					if (restart_c) begin
						state_q <= S_RST;
					end else begin
						if (!cfg.early_change && is_pow2(nf_ext)) begin
							cw_q <= pow2_bits(nf_ext);
						end else if (cfg.early_change && is_pow2(nf_inc)) begin
							cw_q <= pow2_bits(nf_inc);
						end
						state_q <= S_FIN;
					end
				end
				S_RST: begin
					if (out_free) begin
						rv_q    <= '0;
						nf_q    <= FIRST_FREE;
						cw_q    <= BASE_W;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						if (!cfg.early_change && is_pow2(nf_ext)) begin
							cw_q <= pow2_bits(nf_ext);
						end else if (cfg.early_change && is_pow2(nf_inc)) begin
							cw_q <= pow2_bits(nf_inc);
						end
						state_q <= S_EOI;
					end
				end
				S_EOI: begin
					if (out_free) begin
						rv_q    <= '0;
						nf_q    <= FIRST_FREE;
						cw_q    <= BASE_W;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_code_q <= emit_code;
			out_w_q    <= cw_q;
			out_fin_q  <= emit_fin;
		end
	end

	assign code_ext   = {12'd0, out_code_q};
	assign w_ext      = {4'd0, out_w_q};
	assign code       = code_ext[CODE_W-1:0];
	assign code_width = w_ext[CWIDTH_W-1:0];
	assign final_code = out_fin_q;
	assign out_valid  = out_valid_q;

endmodule
